// File: rtl/lrq_pkg.sv
// Shared types, constants and codes for the coalescing load request queue.
package lrq_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int BATCH_MAX     = 8;
  localparam int SLOT_W        = $clog2(PENDING_DEPTH);
  localparam int CNT_W         = $clog2(BATCH_MAX + 1);
  localparam int DEPTH_W       = $clog2(PENDING_DEPTH + 1);
  localparam int MEM_DEPTH     = PENDING_DEPTH * BATCH_MAX;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int FIELD_W       = 10;
  localparam int LIMIT_W       = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd16;

  typedef enum logic [0:0] {
    CMD_ENQUEUE = 1'b0,
    CMD_FINISH  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ENQ_ACK = 2'd0,
    KIND_FIN_ACK = 2'd1,
    KIND_MEMBER  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_NEW_BATCH  = 3'd0,
    ST_MERGED     = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_BATCH_FULL = 3'd3,
    ST_FINISHED   = 3'd4,
    ST_FIN_IGNORE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_ACK  = 2'd1,
    B_MEMB = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [7:0]  source;
    logic [15:0] step;
    logic [4:0]  level;
    logic [7:0]  version;
    logic [19:0] block;
  } key_t;

  // One classified item handed from the front to the back
  typedef struct packed {
    kind_t               ack_kind;
    status_t             ack_status;
    logic [CNT_W-1:0]    ack_size;
    logic                dispatch;
    key_t                key;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    count;
    logic [DEPTH_W-1:0]  depth;
    logic [LIMIT_W-1:0]  outstanding;
  } op_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(PENDING_DEPTH - 1)) r = '0;
    else r = p + SLOT_W'(1);
    return r;
  endfunction

endpackage

// File: rtl/coalescing_load_request_queue_unit.sv
// Top level of the coalescing load request queue.
// Each item, once taken, gives one acknowledgement and, when a batch goes out,
// one result per member of that batch (up to 8); busy stays high until the
// last result of the item has been shown, and the next item can be taken
// only once busy is low, so items never overlap. The front stage does key
// match and state update on the captured item, the back stage shows the
// results in turn, paced by the member RAM read port. Results appear for one
// cycle each under strobe and cannot be held off; configuration is taken
// whenever busy is low.
module coalescing_load_request_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  source_tag,
  input  logic [15:0] step_index,
  input  logic [4:0]  level_index,
  input  logic [7:0]  version_number,
  input  logic [19:0] block_index,
  input  logic [9:0]  field_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [7:0]  out_source,
  output logic [15:0] out_step,
  output logic [4:0]  out_level,
  output logic [7:0]  out_version,
  output logic [19:0] out_block,
  output logic [9:0]  out_field,
  output logic [3:0]  batch_size,
  output logic [4:0]  wait_depth,
  output logic [7:0]  outstanding,
  output logic        last
);

  logic                          take;
  logic                          pending;
  logic                          active;
  logic                          q_full, q_empty, q_push, q_pop;
  lrq_pkg::op_t                  q_in, q_out;
  logic                          mem_wr_en;
  logic [lrq_pkg::MEM_AW-1:0]    mem_wr_addr, mem_rd_addr;
  logic [lrq_pkg::FIELD_W-1:0]   mem_wr_data, mem_rd_data;
  lrq_pkg::key_t                 in_key, res_key;
  logic [lrq_pkg::CNT_W-1:0]     size_w;
  logic [lrq_pkg::DEPTH_W-1:0]   depth_w;

  // Handshakes
  assign busy      = pending || !q_empty || active;
  assign take      = start && !busy;
  assign cfg_ready = !busy;

  assign in_key = '{source: source_tag, step: step_index, level: level_index,
                    version: version_number, block: block_index};

  lrq_front u_front (
    .clk, .rst, .take,
    .cmd        (lrq_pkg::cmd_t'(cmd)),
    .key        (in_key),
    .field      (field_index),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data,
    .pending,
    .q_full,
    .q_push,
    .q_data     (q_in),
    .mem_wr_en, .mem_wr_addr, .mem_wr_data
  );

  lrq_fifo u_fifo (
    .clk, .rst,
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lrq_ram #(.WIDTH(lrq_pkg::FIELD_W), .DEPTH(lrq_pkg::MEM_DEPTH)) u_members (
    .clk,
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lrq_back u_back (
    .clk, .rst, .q_empty,
    .q_data      (q_out),
    .q_pop,
    .active,
    .mem_rd_addr,
    .mem_rd_data,
    .strobe,
    .kind,
    .status,
    .out_key     (res_key),
    .out_field,
    .batch_size  (size_w),
    .wait_depth  (depth_w),
    .outstanding,
    .last
  );

  // Unpack result key and fit widths
  assign out_source  = res_key.source;
  assign out_step    = res_key.step;
  assign out_level   = res_key.level;
  assign out_version = res_key.version;
  assign out_block   = res_key.block;
  assign batch_size  = 4'(size_w);
  assign wait_depth  = 5'(depth_w);

  // Results only while busy
  a_strobe: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result while idle");
  // Nothing follows the last result of an item
  a_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result after last");
  // Config is never written while results are pending
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !strobe)
    else $error("config write during results");

endmodule

// File: rtl/lrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/lrq_fifo.sv
// Two-entry queue of classified items between front and back.
module lrq_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lrq_pkg::op_t   push_data,
  output logic           full,
  input  logic           pop,
  output lrq_pkg::op_t   pop_data,
  output logic           empty
);

  lrq_pkg::op_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = entries[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      if ((push && !full) && !(pop && !empty)) fill <= fill + 2'd1;
      else if (!(push && !full) && (pop && !empty)) fill <= fill - 2'd1;
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/lrq_front.sv
// Front end: takes items, matches keys, updates batch state, decides dispatch.
module lrq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  lrq_pkg::cmd_t                 cmd,
  input  lrq_pkg::key_t                 key,
  input  logic [lrq_pkg::FIELD_W-1:0]   field,
  input  logic                          cfg_write,
  input  logic [lrq_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                          pending,
  input  logic                          q_full,
  output logic                          q_push,
  output lrq_pkg::op_t                  q_data,
  output logic                          mem_wr_en,
  output logic [lrq_pkg::MEM_AW-1:0]    mem_wr_addr,
  output logic [lrq_pkg::FIELD_W-1:0]   mem_wr_data
);

  localparam int PD = lrq_pkg::PENDING_DEPTH;
  localparam int SW = lrq_pkg::SLOT_W;
  localparam int CW = lrq_pkg::CNT_W;
  localparam int DW = lrq_pkg::DEPTH_W;
  localparam int LW = lrq_pkg::LIMIT_W;
  localparam int AW = lrq_pkg::MEM_AW;

  // Captured item
  logic                        st_valid;
  lrq_pkg::cmd_t               st_cmd;
  lrq_pkg::key_t               st_key;
  logic [lrq_pkg::FIELD_W-1:0] st_field;

  // Batch state
  lrq_pkg::key_t keys [PD];
  logic [CW-1:0] counts [PD];
  logic [CW-1:0] counts_next [PD];
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [DW-1:0] waiting, waiting_next;
  logic [LW-1:0] outstanding, outstanding_next;
  logic [LW-1:0] flight_limit;

  logic          hit;
  logic [SW-1:0] hit_slot;
  logic [CW-1:0] hit_cnt;
  logic          open_new;
  logic          fire;

  assign pending = st_valid;
  assign fire    = st_valid && !q_full;
  assign q_push  = fire;

  // Match key against waiting batches
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int j = 0; j < PD; j++) begin
      if (counts[j] != '0 && keys[j] == st_key) begin
        hit      = 1'b1;
        hit_slot = SW'(j);
      end
    end
    hit_cnt = counts[hit_slot];
  end

  // Classify item, update state, decide dispatch
  always_comb begin
    for (int j = 0; j < PD; j++) counts_next[j] = counts[j];
    head_next        = head;
    tail_next        = tail;
    waiting_next     = waiting;
    outstanding_next = outstanding;
    open_new         = 1'b0;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = '0;
    mem_wr_data      = st_field;
    q_data           = '0;

    if (st_cmd == lrq_pkg::CMD_ENQUEUE) begin
      q_data.ack_kind = lrq_pkg::KIND_ENQ_ACK;
      if (hit) begin
        if (hit_cnt >= CW'(lrq_pkg::BATCH_MAX)) begin
          q_data.ack_status = lrq_pkg::ST_BATCH_FULL;
          q_data.ack_size   = hit_cnt;
        end else begin
          q_data.ack_status     = lrq_pkg::ST_MERGED;
          q_data.ack_size       = hit_cnt + CW'(1);
          counts_next[hit_slot] = hit_cnt + CW'(1);
          mem_wr_en   = fire;
          mem_wr_addr = AW'(hit_slot) * AW'(lrq_pkg::BATCH_MAX) + AW'(hit_cnt);
        end
      end else if (waiting >= DW'(PD)) begin
        q_data.ack_status = lrq_pkg::ST_QUEUE_FULL;
        q_data.ack_size   = '0;
      end else begin
        q_data.ack_status = lrq_pkg::ST_NEW_BATCH;
        q_data.ack_size   = CW'(1);
        open_new          = 1'b1;
        counts_next[tail] = CW'(1);
        tail_next         = lrq_pkg::next_slot(tail);
        waiting_next      = waiting + DW'(1);
        mem_wr_en   = fire;
        mem_wr_addr = AW'(tail) * AW'(lrq_pkg::BATCH_MAX);
      end
    end else begin
      q_data.ack_kind = lrq_pkg::KIND_FIN_ACK;
      q_data.ack_size = '0;
      if (outstanding != '0) begin
        q_data.ack_status = lrq_pkg::ST_FINISHED;
        outstanding_next  = outstanding - LW'(1);
      end else begin
        q_data.ack_status = lrq_pkg::ST_FIN_IGNORE;
      end
    end

    // Dispatch head batch when the limit allows
    q_data.slot  = head;
    q_data.count = counts_next[head];
    q_data.key   = (open_new && tail == head) ? st_key : keys[head];
    if (waiting_next != '0 && outstanding_next < flight_limit) begin
      q_data.dispatch   = 1'b1;
      head_next         = lrq_pkg::next_slot(head);
      waiting_next      = waiting_next - DW'(1);
      outstanding_next  = outstanding_next + LW'(1);
      counts_next[head] = '0;
    end
    q_data.depth       = waiting_next;
    q_data.outstanding = outstanding_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid     <= 1'b0;
      head         <= '0;
      tail         <= '0;
      waiting      <= '0;
      outstanding  <= '0;
      flight_limit <= lrq_pkg::LIMIT_RESET;
      for (int j = 0; j < PD; j++) counts[j] <= '0;
    end else begin
      if (cfg_write) flight_limit <= cfg_data;
      if (take) st_valid <= 1'b1;
      else if (fire) st_valid <= 1'b0;
      if (fire) begin
        head        <= head_next;
        tail        <= tail_next;
        waiting     <= waiting_next;
        outstanding <= outstanding_next;
        for (int j = 0; j < PD; j++) counts[j] <= counts_next[j];
      end
    end
  end

  // Capture item and store new keys
  always_ff @(posedge clk) begin
    if (take) begin
      st_cmd   <= cmd;
      st_key   <= key;
      st_field <= field;
    end
    if (fire && open_new) keys[tail] <= st_key;
  end

  // Waiting count never exceeds the pending depth
  a_depth: assert property (@(posedge clk) disable iff (rst) waiting <= DW'(PD))
    else $error("waiting count above depth");
  // A new item is never taken over one still held
  a_take: assert property (@(posedge clk) disable iff (rst) take |-> !st_valid)
    else $error("item taken while stage full");
  // Queue full drop only when all slots are waiting
  a_full: assert property (@(posedge clk) disable iff (rst)
    (fire && q_data.ack_status == lrq_pkg::ST_QUEUE_FULL &&
     q_data.ack_kind == lrq_pkg::KIND_ENQ_ACK) |-> waiting == DW'(PD))
    else $error("queue full drop with free slot");

endmodule

// File: rtl/lrq_back.sv
// Back end: emits the acknowledgement, then reads out batch members when a batch is dispatched.
module lrq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lrq_pkg::op_t                  q_data,
  output logic                          q_pop,
  output logic                          active,
  output logic [lrq_pkg::MEM_AW-1:0]    mem_rd_addr,
  input  logic [lrq_pkg::FIELD_W-1:0]   mem_rd_data,
  output logic                          strobe,
  output logic [1:0]                    kind,
  output logic [2:0]                    status,
  output lrq_pkg::key_t                 out_key,
  output logic [lrq_pkg::FIELD_W-1:0]   out_field,
  output logic [lrq_pkg::CNT_W-1:0]     batch_size,
  output logic [lrq_pkg::DEPTH_W-1:0]   wait_depth,
  output logic [lrq_pkg::LIMIT_W-1:0]   outstanding,
  output logic                          last
);

  localparam int CW = lrq_pkg::CNT_W;
  localparam int AW = lrq_pkg::MEM_AW;

  lrq_pkg::back_state_t state, state_next;
  lrq_pkg::op_t         op;
  logic [CW-1:0]        idx, idx_next;
  logic [AW-1:0]        base;

  assign base   = AW'(op.slot) * AW'(lrq_pkg::BATCH_MAX);
  assign active = (state != lrq_pkg::B_IDLE);
  assign q_pop  = (state == lrq_pkg::B_IDLE) && !q_empty;

  // Sequence results
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    mem_rd_addr = base;
    strobe      = 1'b0;
    kind        = lrq_pkg::KIND_ENQ_ACK;
    status      = lrq_pkg::ST_NEW_BATCH;
    out_key     = '0;
    out_field   = '0;
    batch_size  = '0;
    wait_depth  = op.depth;
    outstanding = op.outstanding;
    last        = 1'b0;
    case (state)
      lrq_pkg::B_IDLE: begin
        if (!q_empty) state_next = lrq_pkg::B_ACK;
      end
      lrq_pkg::B_ACK: begin
        strobe     = 1'b1;
        kind       = op.ack_kind;
        status     = op.ack_status;
        batch_size = op.ack_size;
        last       = !op.dispatch;
        idx_next   = '0;
        state_next = op.dispatch ? lrq_pkg::B_MEMB : lrq_pkg::B_IDLE;
      end
      lrq_pkg::B_MEMB: begin
        strobe      = 1'b1;
        kind        = lrq_pkg::KIND_MEMBER;
        out_key     = op.key;
        out_field   = mem_rd_data;
        batch_size  = op.count;
        last        = (idx + CW'(1) >= op.count);
        mem_rd_addr = base + AW'(idx) + AW'(1);
        idx_next    = idx + CW'(1);
        if (last) state_next = lrq_pkg::B_IDLE;
      end
      default: state_next = lrq_pkg::B_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrq_pkg::B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Hold popped item
  always_ff @(posedge clk) begin
    if (q_pop) op <= q_data;
  end

  // Members never outrun the batch
  a_idx: assert property (@(posedge clk) disable iff (rst)
    (state == lrq_pkg::B_MEMB) |-> idx < op.count)
    else $error("member index past batch");
  // An ack follows every pop
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == lrq_pkg::B_ACK)
    else $error("pop without ack");
  // A dispatched batch is never empty
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == lrq_pkg::B_ACK && op.dispatch) |-> op.count != '0)
    else $error("empty batch dispatched");

endmodule
